// ===== sv/adsl_pkg.sv =====
// Shared constants and controller/datapath interface types for the die and section lookup.
`default_nettype none
package adsl_pkg;

    // Fixed field widths and table sizes.
    localparam int ADDR_BITS    = 48;
    localparam int MAX_DIES     = 8;
    localparam int MAX_SECTIONS = 64;
    localparam int DIE_W        = 3;
    localparam int SEC_W        = 6;
    localparam int CNT_W        = 7;
    localparam int PTR_W        = 7;
    localparam int DC_W         = 4;
    localparam int SS_W         = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int MEM_AW       = DIE_W + SEC_W;

    // Beat layouts.
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_DIE_WR = 2'd0;
    localparam logic [1:0] OP_SEC_WR = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_SIZE = 2'd1;

    // Reset value of the section size register.
    localparam logic [SS_W-1:0] SECTION_SIZE_RESET = 6'd28;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic die_step;
        logic sec_read;
        logic sec_cmp;
        logic out_load;
    } adsl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic at_edge;
        logic die_hit;
        logic sec_hit;
    } adsl_status_t;

endpackage
`default_nettype wire

// ===== sv/adsl_dpath.sv =====
// Datapath: configuration, die tables, section memory, search bounds and result registers.
`default_nettype none
module adsl_dpath import adsl_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SS_W-1:0]       cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire adsl_cmd_t             cmd,
    output adsl_status_t               status,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    // Input beat fields.
    logic [ADDR_BITS-1:0] in_addr;
    logic [ADDR_BITS-1:0] in_end;
    logic [DIE_W-1:0]     in_die;
    logic [SEC_W-1:0]     in_sec;
    logic [CNT_W-1:0]     in_cnt;

    assign in_addr = s_tdata[47:0];
    assign in_end  = s_tdata[95:48];
    assign in_die  = s_tdata[98:96];
    assign in_sec  = s_tdata[104:99];
    assign in_cnt  = s_tdata[111:105];

    // Configuration registers.
    logic [DC_W-1:0] die_count_reg;
    logic [SS_W-1:0] section_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            die_count_reg    <= '0;
            section_size_reg <= SECTION_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DIE_COUNT:    die_count_reg    <= cfg_data[DC_W-1:0];
                REG_SECTION_SIZE: section_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Die tables; only the section counts have a defined reset value.
    logic [ADDR_BITS-1:0] die_start_reg [MAX_DIES];
    logic [ADDR_BITS-1:0] die_end_reg   [MAX_DIES];
    logic [CNT_W-1:0]     die_cnt_reg   [MAX_DIES];

    logic die_wr;
    logic sec_wr;
    assign die_wr = cmd.load && (s_tuser == OP_DIE_WR);
    assign sec_wr = cmd.load && (s_tuser == OP_SEC_WR);

    always_ff @(posedge aclk) begin
        if (die_wr) begin
            die_start_reg[in_die] <= in_addr;
            die_end_reg[in_die]   <= in_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIES; i++) begin
                die_cnt_reg[i] <= '0;
            end
        end else if (die_wr) begin
            die_cnt_reg[in_die] <= in_cnt;
        end
    end

    // Search bounds and probe point.
    logic [PTR_W-1:0] lo_reg;
    logic [PTR_W-1:0] hi_reg;
    logic [PTR_W:0]   mid_sum;
    logic [PTR_W-1:0] mid;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[PTR_W:1];

    // Section start memory with a registered read port.
    logic [ADDR_BITS-1:0] sec_mem [MAX_DIES*MAX_SECTIONS];
    logic [ADDR_BITS-1:0] rd_reg;
    logic [DIE_W-1:0]     die_num_reg;

    always_ff @(posedge aclk) begin
        if (sec_wr) begin
            sec_mem[{in_die, in_sec}] <= in_addr;
        end
        if (cmd.sec_read) begin
            rd_reg <= sec_mem[{die_num_reg, mid[SEC_W-1:0]}];
        end
    end

    // Address alignment to the section size.
    logic [ADDR_BITS-1:0] align_mask;
    assign align_mask = (section_size_reg >= SS_W'(ADDR_BITS)) ? '0 :
                        ({ADDR_BITS{1'b1}} << section_size_reg);

    // Bound limits for the two searches.
    logic [PTR_W-1:0] die_lim;
    logic [CNT_W-1:0] cnt_at_mid;
    logic [PTR_W-1:0] sec_lim;

    assign die_lim    = (die_count_reg > DC_W'(MAX_DIES)) ? PTR_W'(MAX_DIES) :
                        PTR_W'(die_count_reg);
    assign cnt_at_mid = die_cnt_reg[mid[DIE_W-1:0]];
    assign sec_lim    = (cnt_at_mid > CNT_W'(MAX_SECTIONS)) ? PTR_W'(MAX_SECTIONS) :
                        PTR_W'(cnt_at_mid);

    // Probe compares.
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] aligned_reg;
    logic                 above_end;

    assign above_end      = addr_reg >= die_end_reg[mid[DIE_W-1:0]];
    assign status.die_hit = (addr_reg >= die_start_reg[mid[DIE_W-1:0]]) && !above_end;
    assign status.sec_hit = aligned_reg == rd_reg;
    assign status.empty   = lo_reg == hi_reg;
    assign status.at_edge = (lo_reg == mid) || (hi_reg == mid);

    // Result fields, built up over the two searches.
    logic             die_found_reg;
    logic             sec_found_reg;
    logic [SEC_W-1:0] sec_num_reg;
    logic [ADDR_BITS-1:0] sec_start_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg      <= in_addr;
            aligned_reg   <= in_addr & align_mask;
            lo_reg        <= '0;
            hi_reg        <= die_lim;
            die_found_reg <= 1'b0;
            die_num_reg   <= '0;
            sec_found_reg <= 1'b0;
            sec_num_reg   <= '0;
            sec_start_reg <= '0;
        end else if (cmd.die_step) begin
            if (status.die_hit) begin
                die_found_reg <= 1'b1;
                die_num_reg   <= mid[DIE_W-1:0];
                lo_reg        <= '0;
                hi_reg        <= sec_lim;
            end else if (above_end) begin
                lo_reg <= mid;
            end else begin
                hi_reg <= mid;
            end
        end else if (cmd.sec_cmp) begin
            if (status.sec_hit) begin
                sec_found_reg <= 1'b1;
                sec_num_reg   <= mid[SEC_W-1:0];
                sec_start_reg <= rd_reg;
            end else if (aligned_reg > rd_reg) begin
                lo_reg <= mid;
            end else begin
                hi_reg <= mid;
            end
        end
        // Output register; writes and unused codes leave a zero result.
        if (cmd.out_load) begin
            m_tdata_reg <= {5'd0, sec_start_reg, sec_num_reg, sec_found_reg,
                            die_num_reg, die_found_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule
`default_nettype wire

// ===== sv/adsl_ctrl.sv =====
// Controller: sequences item acceptance, the die search, the section search and the result beat.
`default_nettype none
module adsl_ctrl import adsl_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire adsl_status_t         status,
    output adsl_cmd_t                 cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIE,
        ST_SREAD,
        ST_SCMP,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Commands decoded from the state.
    always_comb begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.die_step = (state_reg == ST_DIE) && !status.empty;
        cmd.sec_read = (state_reg == ST_SREAD) && !status.empty;
        cmd.sec_cmp  = state_reg == ST_SCMP;
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A new result beat replaces the one leaving; otherwise a taken beat clears.
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= (s_tuser == OP_LOOKUP) ? ST_DIE : ST_DONE;
                    end
                end
                ST_DIE: begin
                    if (status.empty) begin
                        state_reg <= ST_DONE;
                    end else if (status.die_hit) begin
                        state_reg <= ST_SREAD;
                    end else if (status.at_edge) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SREAD: begin
                    state_reg <= status.empty ? ST_DONE : ST_SCMP;
                end
                ST_SCMP: begin
                    if (status.sec_hit || status.at_edge) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_SREAD;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/address_to_die_section_lookup.sv =====
// Top level of the address to die and section lookup.
//
// Items arrive as beats on the s_ channel; tuser selects the operation: write a
// die entry (start, exclusive end, section count), write one section start, or
// look up an address. Every item yields exactly one beat on the m_ channel;
// writes and unused codes return an all-zero result.
// A lookup aligns the address down to the section size as it is accepted,
// binary-searches the die table (one probe per cycle, up to four probes),
// then binary-searches that die's section starts. Each section probe first
// reads the section memory, which has a registered read port, and then
// compares; up to seven probes are made. One item is in work at a time.
// The result sits in an output register, so the next item is accepted while
// a result beat still waits; a stalled receiver holds the block only when a
// second result is ready. The configuration channel is always ready.
// Synchronous reset clears the die count, section size (to 28), die section
// counts and all control state; die and section tables are undefined until
// written.
`default_nettype none
module address_to_die_section_lookup import adsl_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SS_W-1:0]       cfg_data,
    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // address[47:0], range_end[95:48], die_index[98:96], section_index[104:99],
    // section_count[111:105]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // die_found[0], die_number[3:1], section_found[4], section_number[10:5],
    // section_start[58:11], zero[63:59]
    output logic [M_TDATA_W-1:0]       m_tdata
);

    adsl_cmd_t    cmd;
    adsl_status_t status;

    assign cfg_ready = 1'b1;

    adsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsl_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

    // The block is busy right after it takes an item.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was still in work");

    // A section match is only reported inside a found die.
    a_section_needs_die: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> m_tdata[0])
        else $error("section found without a die");

    // Without a die every section field is zero.
    a_no_die_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[58:1] == '0))
        else $error("nonzero fields in a result without a die");

endmodule
`default_nettype wire
